// ===== rtl/core/pcs_pkg.sv =====
// Shared types, constants and register codes of the saturating PID controller.
package pcs_pkg;

   localparam int DATA_W     = 16;
   localparam int ACC_W      = 48;
   localparam int GAIN_W     = 24;
   localparam int TIME_W     = 16;
   localparam int MUL_W      = 24;
   localparam int MUL_P_W    = 2 * MUL_W;
   localparam int PROD_W     = 3 * MUL_W;
   localparam int Q_SHIFT    = 12;
   localparam int DIV_NUM_W  = PROD_W - Q_SHIFT;
   localparam int DIV_DEN_W  = 20;
   localparam int DIV_STEPS  = DIV_NUM_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int SUM_W      = 62;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;

   localparam int unsigned US_PER_S = 1000000;

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic signed [GAIN_W-1:0] GAIN_P_RESET     = 24'sd10240;
   localparam logic signed [GAIN_W-1:0] GAIN_I_RESET     = 24'sd102400;
   localparam logic signed [GAIN_W-1:0] GAIN_D_RESET     = 24'sd61;
   localparam logic                     CLAMP_EN_RESET   = 1'b1;
   localparam logic signed [DATA_W-1:0] LIMIT_LOW_RESET  = -16'sd4096;
   localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RESET = 16'sd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_CLAMP_EN   = 3'd3,
      CSR_LIMIT_LOW  = 3'd4,
      CSR_LIMIT_HIGH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic                     clamp_enable;
      logic signed [DATA_W-1:0] limit_low;
      logic signed [DATA_W-1:0] limit_high;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INC,
      S_P,
      S_I0,
      S_I1,
      S_D0,
      S_DIV_I,
      S_WAIT_I,
      S_D1,
      S_D2,
      S_D3,
      S_DIV_D,
      S_WAIT_D,
      S_OUT
   } seq_state_type;

endpackage

// ===== rtl/core/pcs_csr.sv =====
// Configuration register file of the saturating PID controller.
module pcs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output pcs_pkg::cfg_type                   cfg
);

   pcs_pkg::cfg_type cfg_ff;
   pcs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pcs_pkg::CSR_GAIN_P: begin
               cfg_in.gain_p = pcs_pkg::GAIN_W'(csr_write_data);
            end
            pcs_pkg::CSR_GAIN_I: begin
               cfg_in.gain_i = pcs_pkg::GAIN_W'(csr_write_data);
            end
            pcs_pkg::CSR_GAIN_D: begin
               cfg_in.gain_d = pcs_pkg::GAIN_W'(csr_write_data);
            end
            pcs_pkg::CSR_CLAMP_EN: begin
               cfg_in.clamp_enable = csr_write_data[0];
            end
            pcs_pkg::CSR_LIMIT_LOW: begin
               cfg_in.limit_low = csr_write_data[pcs_pkg::DATA_W-1:0];
            end
            pcs_pkg::CSR_LIMIT_HIGH: begin
               cfg_in.limit_high = csr_write_data[pcs_pkg::DATA_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p       <= pcs_pkg::GAIN_P_RESET;
         cfg_ff.gain_i       <= pcs_pkg::GAIN_I_RESET;
         cfg_ff.gain_d       <= pcs_pkg::GAIN_D_RESET;
         cfg_ff.clamp_enable <= pcs_pkg::CLAMP_EN_RESET;
         cfg_ff.limit_low    <= pcs_pkg::LIMIT_LOW_RESET;
         cfg_ff.limit_high   <= pcs_pkg::LIMIT_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/pcs_div.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
module pcs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pcs_pkg::div_req_type  div_req,
   output pcs_pkg::div_rsp_type  div_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [pcs_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [pcs_pkg::DIV_NUM_W-1:0]     quo_ff, quo_in;
   logic [pcs_pkg::DIV_DEN_W-1:0]     rem_ff, rem_in;
   logic [pcs_pkg::DIV_DEN_W-1:0]     den_ff, den_in;

   logic [pcs_pkg::DIV_DEN_W:0]       r1, r2, diff1, diff2;
   logic [pcs_pkg::DIV_DEN_W-1:0]     rem1, rem2;
   logic                              b1, b2;

   always_comb begin
      r1    = {rem_ff, quo_ff[pcs_pkg::DIV_NUM_W-1]};
      diff1 = r1 - {1'b0, den_ff};
      b1    = (r1 >= {1'b0, den_ff});
      rem1  = b1 ? diff1[pcs_pkg::DIV_DEN_W-1:0] : r1[pcs_pkg::DIV_DEN_W-1:0];
      r2    = {rem1, quo_ff[pcs_pkg::DIV_NUM_W-2]};
      diff2 = r2 - {1'b0, den_ff};
      b2    = (r2 >= {1'b0, den_ff});
      rem2  = b2 ? diff2[pcs_pkg::DIV_DEN_W-1:0] : r2[pcs_pkg::DIV_DEN_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_STEPS - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[pcs_pkg::DIV_NUM_W-3:0], b1, b2};
         rem_in = rem2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/pid_controller_saturating_core.sv =====
// Top level of the saturating PID controller: sequencer, shared multiplier and output stage.
//
//   channel  direction  handshake                    payload
//   req      in         req_valid / req_ready        req_error_value, req_elapsed_us
//   rsp      out        rsp_valid / rsp_ready        rsp_drive, rsp_clamped
//   csr      in         csr_write_enable             csr_index, csr_write_data
//
// A transaction runs from acceptance to a loaded result through two 30-step passes through
// the shared divider (I term, then D term), each ending with a done pulse, and the steps
// of the shared 24x24 multiplier. With zero elapsed time the D pass is skipped. req_ready
// is high only in the idle state, so a new transaction is accepted only after the result
// of the last one has loaded into the output register.
// A result waits in the output register while the next transaction is accepted; the
// second result holds in the sequencer until rsp is taken.
// Reset is synchronous: it clears the integral and the last error and loads the register
// defaults.
module pid_controller_saturating_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pcs_pkg::DATA_W-1:0]    req_error_value,
   input  logic [pcs_pkg::TIME_W-1:0]           req_elapsed_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pcs_pkg::DATA_W-1:0]    rsp_drive,
   output logic                                 rsp_clamped,
   input  logic                                 csr_write_enable,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   pcs_pkg::cfg_type        cfg;
   pcs_pkg::div_req_type    div_req;
   pcs_pkg::div_rsp_type    div_rsp;

   pcs_pkg::seq_state_type  state_ff, state_in;

   logic signed [pcs_pkg::ACC_W-1:0]   integral_ff, integral_in;
   logic signed [pcs_pkg::DATA_W-1:0]  last_error_ff, last_error_in;
   logic [pcs_pkg::DATA_W-1:0]         e_mag_ff, e_mag_in;
   logic                               e_neg_ff, e_neg_in;
   logic [pcs_pkg::DATA_W-1:0]         diff_mag_ff, diff_mag_in;
   logic                               diff_neg_ff, diff_neg_in;
   logic [pcs_pkg::TIME_W-1:0]         t_ff, t_in;
   logic [pcs_pkg::MUL_P_W-1:0]        mul_ff, mul_in;
   logic [pcs_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic [pcs_pkg::MUL_P_W-1:0]        dprod_ff, dprod_in;
   logic signed [pcs_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [pcs_pkg::DATA_W-1:0]  rsp_drive_ff, rsp_drive_in;
   logic                               rsp_clamped_ff, rsp_clamped_in;

   logic [pcs_pkg::MUL_W-1:0]          mul_a, mul_b;
   logic [pcs_pkg::MUL_W-1:0]          gp_mag, gi_mag, gd_mag;
   logic [pcs_pkg::ACC_W-1:0]          acc_mag;
   logic                               p_neg, i_neg, d_neg;
   logic                               req_accept, out_load;
   logic signed [pcs_pkg::DATA_W:0]    e_ext, diff_ext;
   logic signed [pcs_pkg::ACC_W:0]     acc_sum;
   logic [pcs_pkg::ACC_W:0]            inc_ext;
   logic [pcs_pkg::SUM_W-1:0]          term_mag;
   logic signed [pcs_pkg::SUM_W-1:0]   res;

   pcs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pcs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign gp_mag  = cfg.gain_p[pcs_pkg::GAIN_W-1] ? pcs_pkg::MUL_W'(-cfg.gain_p)
                                                   : pcs_pkg::MUL_W'(cfg.gain_p);
   assign gi_mag  = cfg.gain_i[pcs_pkg::GAIN_W-1] ? pcs_pkg::MUL_W'(-cfg.gain_i)
                                                   : pcs_pkg::MUL_W'(cfg.gain_i);
   assign gd_mag  = cfg.gain_d[pcs_pkg::GAIN_W-1] ? pcs_pkg::MUL_W'(-cfg.gain_d)
                                                   : pcs_pkg::MUL_W'(cfg.gain_d);
   assign acc_mag = integral_ff[pcs_pkg::ACC_W-1] ? pcs_pkg::ACC_W'(-integral_ff)
                                                   : pcs_pkg::ACC_W'(integral_ff);

   assign p_neg = cfg.gain_p[pcs_pkg::GAIN_W-1] ^ e_neg_ff;
   assign i_neg = cfg.gain_i[pcs_pkg::GAIN_W-1] ^ integral_ff[pcs_pkg::ACC_W-1];
   assign d_neg = cfg.gain_d[pcs_pkg::GAIN_W-1] ^ diff_neg_ff;

   assign req_ready  = (state_ff == pcs_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_load   = (state_ff == pcs_pkg::S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcs_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = pcs_pkg::S_INC;
            end
         end
         pcs_pkg::S_INC:   state_in = pcs_pkg::S_P;
         pcs_pkg::S_P:     state_in = pcs_pkg::S_I0;
         pcs_pkg::S_I0:    state_in = pcs_pkg::S_I1;
         pcs_pkg::S_I1:    state_in = pcs_pkg::S_D0;
         pcs_pkg::S_D0:    state_in = pcs_pkg::S_DIV_I;
         pcs_pkg::S_DIV_I: state_in = pcs_pkg::S_WAIT_I;
         pcs_pkg::S_WAIT_I: begin
            if (div_rsp.done) begin
               state_in = pcs_pkg::S_D1;
            end
         end
         pcs_pkg::S_D1:    state_in = pcs_pkg::S_D2;
         pcs_pkg::S_D2:    state_in = pcs_pkg::S_D3;
         pcs_pkg::S_D3:    state_in = pcs_pkg::S_DIV_D;
         pcs_pkg::S_DIV_D: begin
            if (t_ff == '0) begin
               state_in = pcs_pkg::S_OUT;
            end else begin
               state_in = pcs_pkg::S_WAIT_D;
            end
         end
         pcs_pkg::S_WAIT_D: begin
            if (div_rsp.done) begin
               state_in = pcs_pkg::S_OUT;
            end
         end
         pcs_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = pcs_pkg::S_IDLE;
            end
         end
         default: state_in = pcs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      integral_in   = integral_ff;
      last_error_in = last_error_ff;
      e_mag_in      = e_mag_ff;
      e_neg_in      = e_neg_ff;
      diff_mag_in   = diff_mag_ff;
      diff_neg_in   = diff_neg_ff;
      t_in          = t_ff;
      prod_in       = prod_ff;
      dprod_in      = dprod_ff;
      sum_in        = sum_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;
      term_mag      = '0;
      e_ext         = {req_error_value[pcs_pkg::DATA_W-1], req_error_value};
      diff_ext      = e_ext - {last_error_ff[pcs_pkg::DATA_W-1], last_error_ff};
      inc_ext       = {{(pcs_pkg::ACC_W + 1 - 32){1'b0}}, mul_ff[31:0]};
      if (e_neg_ff) begin
         inc_ext = -inc_ext;
      end
      acc_sum = {integral_ff[pcs_pkg::ACC_W-1], integral_ff} + $signed(inc_ext);

      case (state_ff)
         pcs_pkg::S_IDLE: begin
            if (req_accept) begin
               e_neg_in      = req_error_value[pcs_pkg::DATA_W-1];
               e_mag_in      = e_neg_in ? pcs_pkg::DATA_W'(-e_ext)
                                        : pcs_pkg::DATA_W'(e_ext);
               diff_neg_in   = diff_ext[pcs_pkg::DATA_W];
               diff_mag_in   = diff_neg_in ? pcs_pkg::DATA_W'(-diff_ext)
                                           : pcs_pkg::DATA_W'(diff_ext);
               t_in          = req_elapsed_us;
               last_error_in = req_error_value;
            end
         end
         pcs_pkg::S_INC: begin
            mul_a = pcs_pkg::MUL_W'(e_mag_ff);
            mul_b = pcs_pkg::MUL_W'(t_ff);
         end
         pcs_pkg::S_P: begin
            mul_a = gp_mag;
            mul_b = pcs_pkg::MUL_W'(e_mag_ff);
            if (acc_sum[pcs_pkg::ACC_W] != acc_sum[pcs_pkg::ACC_W-1]) begin
               integral_in = acc_sum[pcs_pkg::ACC_W] ? pcs_pkg::ACC_MIN : pcs_pkg::ACC_MAX;
            end else begin
               integral_in = acc_sum[pcs_pkg::ACC_W-1:0];
            end
         end
         pcs_pkg::S_I0: begin
            mul_a    = gi_mag;
            mul_b    = acc_mag[pcs_pkg::MUL_W-1:0];
            term_mag = pcs_pkg::SUM_W'(mul_ff[pcs_pkg::MUL_P_W-1:pcs_pkg::Q_SHIFT]);
            sum_in   = p_neg ? -term_mag : term_mag;
         end
         pcs_pkg::S_I1: begin
            mul_a   = gi_mag;
            mul_b   = acc_mag[pcs_pkg::ACC_W-1:pcs_pkg::MUL_W];
            prod_in = pcs_pkg::PROD_W'(mul_ff);
         end
         pcs_pkg::S_D0: begin
            mul_a   = gd_mag;
            mul_b   = pcs_pkg::MUL_W'(diff_mag_ff);
            prod_in = prod_ff + {mul_ff, {pcs_pkg::MUL_W{1'b0}}};
         end
         pcs_pkg::S_DIV_I: begin
            dprod_in         = mul_ff;
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff[pcs_pkg::PROD_W-1:pcs_pkg::Q_SHIFT];
            div_req.divisor  = pcs_pkg::DIV_DEN_W'(pcs_pkg::US_PER_S);
         end
         pcs_pkg::S_WAIT_I: begin
            if (div_rsp.done) begin
               term_mag = pcs_pkg::SUM_W'(div_rsp.quotient);
               sum_in   = sum_ff + (i_neg ? -term_mag : term_mag);
            end
         end
         pcs_pkg::S_D1: begin
            mul_a = dprod_ff[pcs_pkg::MUL_W-1:0];
            mul_b = pcs_pkg::MUL_W'(pcs_pkg::US_PER_S);
         end
         pcs_pkg::S_D2: begin
            mul_a   = dprod_ff[pcs_pkg::MUL_P_W-1:pcs_pkg::MUL_W];
            mul_b   = pcs_pkg::MUL_W'(pcs_pkg::US_PER_S);
            prod_in = pcs_pkg::PROD_W'(mul_ff);
         end
         pcs_pkg::S_D3: begin
            prod_in = prod_ff + {mul_ff, {pcs_pkg::MUL_W{1'b0}}};
         end
         pcs_pkg::S_DIV_D: begin
            if (t_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = prod_ff[pcs_pkg::PROD_W-1:pcs_pkg::Q_SHIFT];
               div_req.divisor  = pcs_pkg::DIV_DEN_W'(t_ff);
            end
         end
         pcs_pkg::S_WAIT_D: begin
            if (div_rsp.done) begin
               term_mag = pcs_pkg::SUM_W'(div_rsp.quotient);
               sum_in   = sum_ff + (d_neg ? -term_mag : term_mag);
            end
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
      mul_in = mul_a * mul_b;
   end

   always_comb begin
      res = sum_ff;
      if (cfg.clamp_enable) begin
         if (res > pcs_pkg::SUM_W'(cfg.limit_high)) begin
            res = pcs_pkg::SUM_W'(cfg.limit_high);
         end
         if (res < pcs_pkg::SUM_W'(cfg.limit_low)) begin
            res = pcs_pkg::SUM_W'(cfg.limit_low);
         end
      end
      if (res > pcs_pkg::SUM_W'(pcs_pkg::DATA_MAX)) begin
         res = pcs_pkg::SUM_W'(pcs_pkg::DATA_MAX);
      end
      if (res < pcs_pkg::SUM_W'(pcs_pkg::DATA_MIN)) begin
         res = pcs_pkg::SUM_W'(pcs_pkg::DATA_MIN);
      end
      rsp_drive_in   = rsp_drive_ff;
      rsp_clamped_in = rsp_clamped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_drive_in   = res[pcs_pkg::DATA_W-1:0];
         rsp_clamped_in = (res != sum_ff);
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcs_pkg::S_IDLE;
         rsp_valid_ff  <= 1'b0;
         integral_ff   <= '0;
         last_error_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         integral_ff   <= integral_in;
         last_error_ff <= last_error_in;
      end
      e_mag_ff       <= e_mag_in;
      e_neg_ff       <= e_neg_in;
      diff_mag_ff    <= diff_mag_in;
      diff_neg_ff    <= diff_neg_in;
      t_ff           <= t_in;
      mul_ff         <= mul_in;
      prod_ff        <= prod_in;
      dprod_ff       <= dprod_in;
      sum_ff         <= sum_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

endmodule
